// ===== rtl/fda_pkg.sv =====
`default_nettype none
package fda_pkg;

  localparam int unsigned MAX_FRAC_DIGITS = 9;
  localparam int unsigned INT_DIGITS      = 10;
  localparam int unsigned FRAC_W          = 128;
  localparam int unsigned FRAC_POINT      = 124;
  localparam int unsigned FCNT_W          = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int unsigned FIDX_W          = $clog2(MAX_FRAC_DIGITS);
  localparam int unsigned IIDX_W          = $clog2(INT_DIGITS);

  localparam logic [31:0] SAT_INT  = 32'hFFFF_FFFF;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic        REG_FRAC_DIGITS = 1'b0;

  typedef logic [3:0] digit_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FRAC  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_CONV  = 6'b001000,
    ST_LEAD  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    PH_SIGN = 4'b0001,
    PH_INT  = 4'b0010,
    PH_DOT  = 4'b0100,
    PH_FRAC = 4'b1000
  } phase_e;

  typedef struct packed {
    logic clr;
    logic en;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/fda_bcd_cell.sv =====
`default_nettype none
// One BCD digit of a shift-and-add-3 converter chain.
module fda_bcd_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fda_pkg::cell_ctl_t  ctl_i,
  input  wire                 bit_i,
  output logic                bit_o,
  output fda_pkg::digit_t     digit_o
);
  import fda_pkg::*;

  digit_t digit_q, digit_d, adj;

  always_comb begin
    adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    bit_o   = adj[3];
    digit_d = {adj[2:0], bit_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (ctl_i.clr) begin
      digit_q <= '0;
    end else if (ctl_i.en) begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule
`default_nettype wire

// ===== rtl/float_to_decimal_ascii.sv =====
`default_nettype none
// Float to fixed-point decimal text.
// Request in: value_bits_i, an IEEE-754 single, taken when in_valid_i and
// in_ready_o are both high. in_ready_o is high only while the block is idle,
// so one request is in flight at a time.
// Request out: one ASCII character per transfer on char_code_o ('-',
// '0'..'9', '.'), last_o on the final character, overflow_o on every
// character of a saturated string (|int| >= 2^32, Inf, NaN).
// Rounding is half up in magnitude, exact, with carry into the integer part.
// Steps per request: acceptance in the idle state, the fraction state (n =
// fraction digit count, capped at 9, one multiply-by-10 per cycle plus the
// exit check), a rounding state, the shift through the row of ten BCD cells
// (one integer bit per cycle), a state to find the leading digit, then
// one character per cycle while the receiver keeps taking them.
// The output register holds a character until it is taken; a stalled
// receiver just freezes the character sequencer.
// frac_digits sits at byte address 0 of the APB port, reset value 5.
// Reset returns the block to idle with the output register empty.
module float_to_decimal_ascii (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] value_bits_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  char_code_o,
  output logic        last_o,
  output logic        overflow_o
);
  import fda_pkg::*;

  // configuration
  logic [3:0] frac_cfg_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAC_DIGITS) ? {28'd0, frac_cfg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_cfg_q <= 4'd5;
    end else if (psel && penable && pwrite && paddr[2] == REG_FRAC_DIGITS) begin
      frac_cfg_q <= pwdata[3:0];
    end
  end

  state_e state_q, state_d;
  phase_e phase_q;
  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // unpack
  logic        u_neg, u_ovf, u_zero, u_big;
  logic [7:0]  u_ex, u_s;
  logic [23:0] u_m, u_r;
  logic [32:0] u_ip;
  logic [FRAC_W-1:0] u_frac;
  logic [3:0]  u_n;

  always_comb begin
    u_ex   = value_bits_i[30:23];
    u_zero = (u_ex == 8'd0) && (value_bits_i[22:0] == 23'd0);
    u_neg  = value_bits_i[31] && !u_zero;
    u_m    = {u_ex != 8'd0, value_bits_i[22:0]};
    u_big  = (u_ex >= 8'd150);
    u_ovf  = (u_ex >= 8'd159);
    u_s    = (u_ex == 8'd0) ? 8'd149 : 8'd150 - u_ex;
    u_ip   = '0;
    u_r    = '0;
    u_frac = '0;
    if (u_big) begin
      u_ip = {9'd0, u_m} << u_ex[3:0] - 4'd6;
    end else begin
      if (u_s < 8'd24) begin
        u_ip = {9'd0, u_m >> u_s[4:0]};
        u_r  = u_m & ((24'd1 << u_s[4:0]) - 24'd1);
      end else begin
        u_r  = u_m;
      end
      if (u_s <= 8'd124) begin
        u_frac = {104'd0, u_r} << (7'd124 - u_s[6:0]);
      end
    end
    u_n = (frac_cfg_q > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS) : frac_cfg_q;
  end

  logic              neg_q, ovf_q;
  logic [3:0]        n_q;
  logic [32:0]       ip_q;
  logic [FRAC_W-1:0] frac_q, f10;
  logic [FCNT_W-1:0] fcnt_q;
  digit_t            fd_q [MAX_FRAC_DIGITS];
  logic [4:0]        conv_cnt_q;
  logic [31:0]       sh_q;

  assign f10 = {frac_q[FRAC_W-4:0], 3'b000} + {frac_q[FRAC_W-2:0], 1'b0};

  // rounding: half up on the first dropped bit, ripple through fraction
  digit_t      r_fd [MAX_FRAC_DIGITS];
  logic        r_carry, r_ovf;
  logic [32:0] r_ip;

  always_comb begin
    r_carry = frac_q[FRAC_POINT-1];
    for (int i = MAX_FRAC_DIGITS - 1; i >= 0; i--) begin
      r_fd[i] = fd_q[i];
      if (r_carry && (4'(i) < n_q)) begin
        if (fd_q[i] == 4'd9) begin
          r_fd[i] = 4'd0;
        end else begin
          r_fd[i] = fd_q[i] + 4'd1;
          r_carry = 1'b0;
        end
      end
    end
    r_ip  = ip_q + {32'd0, r_carry};
    r_ovf = ovf_q || r_ip[32];
  end

  // BCD cell row: cell 0 is the units digit
  cell_ctl_t cell_ctl;
  logic   cbit [INT_DIGITS+1];
  digit_t dig  [INT_DIGITS];

  assign cell_ctl.clr = (state_q == ST_ROUND);
  assign cell_ctl.en  = (state_q == ST_CONV);
  assign cbit[0]      = sh_q[31];

  for (genvar k = 0; k < INT_DIGITS; k++) begin : g_cell
    fda_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .bit_i   (cbit[k]),
      .bit_o   (cbit[k+1]),
      .digit_o (dig[k])
    );
  end

  // leading digit position
  logic [IIDX_W-1:0] top;
  always_comb begin
    top = '0;
    for (int k = 0; k < INT_DIGITS; k++) begin
      if (dig[k] != 4'd0) top = IIDX_W'(k);
    end
  end

  // character sequencer
  logic [IIDX_W-1:0] idx_q;
  logic [7:0]  e_char;
  logic        e_last, e_load;
  assign e_load = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);

  always_comb begin
    e_char = CH_MINUS;
    e_last = 1'b0;
    unique case (phase_q)
      PH_SIGN: e_char = CH_MINUS;
      PH_INT: begin
        e_char = CH_ZERO + {4'd0, dig[idx_q]};
        e_last = (idx_q == '0) && (n_q == 4'd0);
      end
      PH_DOT: e_char = CH_DOT;
      PH_FRAC: begin
        e_char = CH_ZERO + {4'd0, fd_q[idx_q[FIDX_W-1:0]]};
        e_last = (idx_q == n_q - 4'd1);
      end
      default: e_char = CH_MINUS;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_FRAC;
      ST_FRAC:  if (fcnt_q == FCNT_W'(n_q)) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_CONV;
      ST_CONV:  if (conv_cnt_q == 5'd31) state_d = ST_LEAD;
      ST_LEAD:  state_d = ST_EMIT;
      ST_EMIT:  if (e_load && e_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SIGN;
      out_valid_o <= 1'b0;
      fcnt_q      <= '0;
      conv_cnt_q  <= '0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (e_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          fcnt_q     <= '0;
          conv_cnt_q <= '0;
        end
        ST_FRAC:  if (fcnt_q != FCNT_W'(n_q)) fcnt_q <= fcnt_q + 1'b1;
        ST_CONV:  conv_cnt_q <= conv_cnt_q + 5'd1;
        ST_LEAD: begin
          phase_q <= neg_q ? PH_SIGN : PH_INT;
          idx_q   <= top;
        end
        ST_EMIT: begin
          if (e_load) begin
            unique case (phase_q)
              PH_SIGN: phase_q <= PH_INT;
              PH_INT: begin
                if (idx_q == '0) begin
                  phase_q <= PH_DOT;
                end else begin
                  idx_q <= idx_q - 1'b1;
                end
              end
              PH_DOT: begin
                phase_q <= PH_FRAC;
                idx_q   <= '0;
              end
              PH_FRAC: idx_q <= idx_q + 1'b1;
              default: phase_q <= PH_INT;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q  <= u_neg;
      ovf_q  <= u_ovf;
      ip_q   <= u_ip;
      frac_q <= u_frac;
      n_q    <= u_n;
    end
    if (state_q == ST_FRAC && fcnt_q != FCNT_W'(n_q)) begin
      fd_q[fcnt_q[FIDX_W-1:0]] <= f10[FRAC_W-1:FRAC_POINT];
      frac_q <= {4'd0, f10[FRAC_POINT-1:0]};
    end
    if (state_q == ST_ROUND) begin
      ovf_q <= r_ovf;
      for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
        fd_q[i] <= r_ovf ? 4'd0 : r_fd[i];
      end
      sh_q <= r_ovf ? SAT_INT : r_ip[31:0];
    end
    if (state_q == ST_CONV) begin
      sh_q <= {sh_q[30:0], 1'b0};
    end
    if (e_load) begin
      char_code_o <= e_char;
      last_o      <= e_last;
      overflow_o  <= ovf_q;
    end
  end

`ifndef ASSERT_OFF
  a_accept_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_FRAC) else $error("accept did not start fraction");
  a_round_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |=> state_q == ST_CONV) else $error("round not followed by conv");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> !in_ready_o && !e_load) else $error("busy overlap");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_load && e_last |=> state_q == ST_IDLE) else $error("last char not ending");
`endif

endmodule
`default_nettype wire
